// ===== rtl/smm_pkg.sv =====
// Shared constants and types of the square matrix multiply block.
// Used by smm_mac and square_matrix_multiply; depends on nothing.
package smm_pkg;

	localparam int MAX_SIZE = 8;
	localparam int IDX_W    = 3;
	localparam int SIZE_W   = 4;
	localparam int DATA_W   = 32;
	localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
	localparam int ADDR_W   = $clog2(DEPTH);

	localparam logic [1:0] OP_LOAD_A   = 2'd0;
	localparam logic [1:0] OP_LOAD_B   = 2'd1;
	localparam logic [1:0] OP_MULTIPLY = 2'd2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_SIZE);

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} smm_issue_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] value);
		logic [SIZE_W-1:0] res;
		if (value == '0) begin
			res = SIZE_W'(1);
		end else if (value > SIZE_W'(MAX_SIZE)) begin
			res = SIZE_W'(MAX_SIZE);
		end else begin
			res = value;
		end
		return res;
	endfunction

endpackage

// ===== rtl/smm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Stands alone; instantiated twice by square_matrix_multiply.
module smm_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/smm_mac.sv =====
// Multiply-accumulate pipeline: registered multiply, then a wrapping 32-bit sum.
// Depends on smm_pkg for widths and the issue tag struct.
module smm_mac (
	input  logic                       clk,
	input  logic                       arst_n,
	input  smm_pkg::smm_issue_t        issue,
	input  logic [smm_pkg::DATA_W-1:0] rd_a,
	input  logic [smm_pkg::DATA_W-1:0] rd_b,
	input  logic                       take,
	output logic [smm_pkg::DATA_W-1:0] acc,
	output logic                       done
);

	smm_pkg::smm_issue_t        tag_s1;
	smm_pkg::smm_issue_t        tag_s2;
	logic [smm_pkg::DATA_W-1:0] product_s2;
	logic [smm_pkg::DATA_W-1:0] acc_q;
	logic                       done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			tag_s1 <= issue;
			tag_s2 <= tag_s1;
			if (take) begin
				done_q <= 1'b0;
			end else if (tag_s2.valid && tag_s2.last) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		product_s2 <= rd_a * rd_b;
		if (tag_s2.valid) begin
			acc_q <= tag_s2.first ? product_s2 : acc_q + product_s2;
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

// ===== rtl/square_matrix_multiply.sv =====
// Square matrix multiply block, C = A x B on up to 8 by 8 signed 32-bit elements.
// Input channel (in_valid/in_stall): operation, row, col, element_value.
//   Load A or load B writes one element; loads outside the size in use
//   and operation 3 are dropped. Multiply emits every C element in row-major order.
// Output channel (out_valid/out_stall): out_row, out_col, product_value,
//   last_result marks the final element of a run. An output register parts the
//   sides; a stalled result holds and the sequencer waits before loading the next.
// Config channel (cfg_valid/cfg_ready): matrix_size, 0 acts as 1, above 8 as 8.
//   Ready while no product is in progress.
// Sequencing: each C element needs n reads of the two stores, one per cycle
//   through their single read ports into the one shared multiplier, then the
//   multiply-accumulate pipeline drains before the element is taken.
// Inputs stall from the multiply transfer until the final element is taken.
// Reset: size returns to 8, the sequencer idles, no result is pending. Stored
//   elements are undefined until written.
// Depends on smm_pkg, smm_ram and smm_mac.
module square_matrix_multiply (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  operation,
	input  logic [smm_pkg::IDX_W-1:0]   row,
	input  logic [smm_pkg::IDX_W-1:0]   col,
	input  logic signed [smm_pkg::DATA_W-1:0] element_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [smm_pkg::IDX_W-1:0]   out_row,
	output logic [smm_pkg::IDX_W-1:0]   out_col,
	output logic signed [smm_pkg::DATA_W-1:0] product_value,
	output logic                        last_result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [smm_pkg::SIZE_W-1:0]  matrix_size
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	state_t                       state_q;
	logic [smm_pkg::SIZE_W-1:0]   size_q;
	logic [smm_pkg::IDX_W-1:0]    i_q;
	logic [smm_pkg::IDX_W-1:0]    j_q;
	logic [smm_pkg::IDX_W-1:0]    k_q;
	logic                         out_valid_q;
	logic [smm_pkg::IDX_W-1:0]    out_row_q;
	logic [smm_pkg::IDX_W-1:0]    out_col_q;
	logic [smm_pkg::DATA_W-1:0]   out_value_q;
	logic                         out_last_q;

	logic [smm_pkg::SIZE_W-1:0]   size_m1;
	logic [smm_pkg::IDX_W-1:0]    nm1;
	logic                         in_xfer;
	logic                         in_range;
	logic                         we_a;
	logic                         we_b;
	logic [smm_pkg::ADDR_W-1:0]   waddr;
	logic [smm_pkg::ADDR_W-1:0]   raddr_a;
	logic [smm_pkg::ADDR_W-1:0]   raddr_b;
	logic [smm_pkg::DATA_W-1:0]   rd_a;
	logic [smm_pkg::DATA_W-1:0]   rd_b;
	smm_pkg::smm_issue_t          issue;
	logic [smm_pkg::DATA_W-1:0]   mac_acc;
	logic                         mac_done;
	logic                         out_free;
	logic                         take;
	logic                         elem_last;

	assign size_m1  = size_q - smm_pkg::SIZE_W'(1);
	assign nm1      = size_m1[smm_pkg::IDX_W-1:0];
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign in_range = ({1'b0, row} < size_q) && ({1'b0, col} < size_q);
	assign we_a     = in_xfer && in_range && (operation == smm_pkg::OP_LOAD_A);
	assign we_b     = in_xfer && in_range && (operation == smm_pkg::OP_LOAD_B);
	assign waddr    = {row, col};
	assign raddr_a  = {i_q, k_q};
	assign raddr_b  = {k_q, j_q};

	assign issue.valid = (state_q == ST_ISSUE);
	assign issue.first = (k_q == '0);
	assign issue.last  = (k_q == nm1);

	assign out_free  = !out_valid_q || !out_stall;
	assign take      = (state_q == ST_DRAIN) && mac_done && out_free;
	assign elem_last = (i_q == nm1) && (j_q == nm1);

	smm_ram #(
		.DEPTH(smm_pkg::DEPTH),
		.WIDTH(smm_pkg::DATA_W)
	) u_left_store (
		.clk  (clk),
		.we   (we_a),
		.waddr(waddr),
		.wdata(element_value),
		.raddr(raddr_a),
		.rdata(rd_a)
	);

	smm_ram #(
		.DEPTH(smm_pkg::DEPTH),
		.WIDTH(smm_pkg::DATA_W)
	) u_right_store (
		.clk  (clk),
		.we   (we_b),
		.waddr(waddr),
		.wdata(element_value),
		.raddr(raddr_b),
		.rdata(rd_b)
	);

	smm_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.issue (issue),
		.rd_a  (rd_a),
		.rd_b  (rd_b),
		.take  (take),
		.acc   (mac_acc),
		.done  (mac_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			size_q      <= smm_pkg::SIZE_RESET;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			out_value_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				size_q <= smm_pkg::clamp_size(matrix_size);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && (operation == smm_pkg::OP_MULTIPLY)) begin
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (k_q == nm1) begin
						k_q     <= '0;
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + smm_pkg::IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (take) begin
						out_row_q   <= i_q;
						out_col_q   <= j_q;
						out_value_q <= mac_acc;
						out_last_q  <= elem_last;
						if (elem_last) begin
							state_q <= ST_IDLE;
						end else begin
							if (j_q == nm1) begin
								j_q <= '0;
								i_q <= i_q + smm_pkg::IDX_W'(1);
							end else begin
								j_q <= j_q + smm_pkg::IDX_W'(1);
							end
							state_q <= ST_ISSUE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign out_row       = out_row_q;
	assign out_col       = out_col_q;
	assign product_value = out_value_q;
	assign last_result   = out_last_q;

`ifndef SYNTHESIS
	a_no_done_in_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |-> !mac_done)
		else $error("accumulator reported done while reads still issuing");

	a_idle_k_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (k_q == '0))
		else $error("inner index not cleared while idle");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(take && elem_last) |=> (state_q == ST_IDLE) && out_valid_q && out_last_q)
		else $error("run did not end after final product element");
`endif

endmodule
